// File: src/bpa_pkg.sv
// Shared types, codes and constants of the bitmap page allocator.
package bpa_pkg;

  localparam int ADDR_W    = 48;
  localparam int CNT_W     = 13;
  localparam int CMD_W     = 3;
  localparam int STAT_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int MODE_W    = 3;
  localparam int SRC_W     = 2;

  localparam int MAX_PAGES_DEF     = 4096;
  localparam int PAGE_BITS_DEF     = 12;
  localparam int MAP_WORD_BITS_DEF = 8;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REL   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY = 3'd3;

  localparam logic [STAT_W-1:0] STAT_OK           = 3'd0;
  localparam logic [STAT_W-1:0] STAT_NO_MEM       = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_INIT     = 3'd2;
  localparam logic [STAT_W-1:0] STAT_BAD_ADDR     = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NOT_ALIGNED  = 3'd4;
  localparam logic [STAT_W-1:0] STAT_ALREADY_FREE = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL  = 2'd2;

  // Walk modes over the page map.
  localparam logic [MODE_W-1:0] WM_SCAN = 3'd0;
  localparam logic [MODE_W-1:0] WM_SET  = 3'd1;
  localparam logic [MODE_W-1:0] WM_CHK  = 3'd2;
  localparam logic [MODE_W-1:0] WM_CLR  = 3'd3;
  localparam logic [MODE_W-1:0] WM_REL  = 3'd4;
  localparam logic [MODE_W-1:0] WM_QRY  = 3'd5;

  // Walk start points.
  localparam logic [SRC_W-1:0] SRC_ZERO  = 2'd0;
  localparam logic [SRC_W-1:0] SRC_START = 2'd1;
  localparam logic [SRC_W-1:0] SRC_FIRST = 2'd2;

  typedef struct packed {
    logic              clr_wr;
    logic              load_item;
    logic              calc;
    logic              div_start;
    logic              div_step;
    logic              walk_init;
    logic [SRC_W-1:0]  walk_src;
    logic [MODE_W-1:0] walk_mode;
    logic              ld;
    logic              bit_step;
    logic              wb;
    logic              fc_add_n;
    logic              fc_sub_n;
    logic              take_addr;
    logic              finish;
    logic [STAT_W-1:0] stat;
  } bpa_cmd_t;

  typedef struct packed {
    logic             clr_last;
    logic             enable;
    logic [CMD_W-1:0] cmd;
    logic             misaligned;
    logic             n_zero;
    logic             free_lt_n;
    logic             total_zero;
    logic             addr_ok;
    logic             run_ok;
    logic             div_done;
    logic             word_end;
    logic             step_last;
    logic             walk_end;
    logic             hit;
  } bpa_stat_t;

endpackage

// File: src/bpa_ctrl.sv
// Controller state machine of the bitmap page allocator.
module bpa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             out_stall,
  output logic             out_valid,
  input  bpa_pkg::bpa_stat_t st,
  output bpa_pkg::bpa_cmd_t  cmd
);
  import bpa_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_CALC = 4'd2;
  localparam logic [3:0] S_DEC  = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_RD   = 4'd5;
  localparam logic [3:0] S_LD   = 4'd6;
  localparam logic [3:0] S_BIT  = 4'd7;
  localparam logic [3:0] S_WB   = 4'd8;
  localparam logic [3:0] S_POST = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0]        state_r, state_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;
  logic              out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        state_nxt = S_DONE;
        stat_nxt  = STAT_OK;
        if (!st.enable) begin
          stat_nxt = STAT_NOT_INIT;
        end else begin
          case (st.cmd)
            CMD_ALLOC: begin
              if (st.n_zero || st.free_lt_n || st.total_zero) begin
                stat_nxt = STAT_NO_MEM;
              end else begin
                cmd.walk_init = 1'b1;
                cmd.walk_src  = SRC_ZERO;
                cmd.walk_mode = WM_SCAN;
                mode_nxt      = WM_SCAN;
                state_nxt     = S_RD;
              end
            end
            CMD_FREE, CMD_REL: begin
              if (st.misaligned) begin
                stat_nxt = STAT_NOT_ALIGNED;
              end else if (st.n_zero) begin
                stat_nxt = STAT_OK;
              end else if (!st.run_ok) begin
                stat_nxt = STAT_BAD_ADDR;
              end else begin
                cmd.div_start = 1'b1;
                mode_nxt      = (st.cmd == CMD_FREE) ? WM_CHK : WM_REL;
                state_nxt     = S_DIV;
              end
            end
            CMD_QUERY: begin
              if (st.misaligned) begin
                stat_nxt = STAT_NOT_ALIGNED;
              end else if (!st.addr_ok) begin
                stat_nxt = STAT_BAD_ADDR;
              end else begin
                cmd.div_start = 1'b1;
                mode_nxt      = WM_QRY;
                state_nxt     = S_DIV;
              end
            end
            default: stat_nxt = STAT_OK;
          endcase
        end
      end
      S_DIV: begin
        if (st.div_done) begin
          cmd.walk_init = 1'b1;
          cmd.walk_src  = SRC_FIRST;
          cmd.walk_mode = mode_r;
          state_nxt     = S_RD;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_RD: state_nxt = S_LD;
      S_LD: begin
        cmd.ld    = 1'b1;
        state_nxt = S_BIT;
      end
      S_BIT: begin
        cmd.bit_step = 1'b1;
        if (st.step_last || st.word_end) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        cmd.wb    = 1'b1;
        state_nxt = st.walk_end ? S_POST : S_RD;
      end
      S_POST: begin
        state_nxt = S_DONE;
        stat_nxt  = STAT_OK;
        case (mode_r)
          WM_SCAN: begin
            if (st.hit) begin
              cmd.walk_init = 1'b1;
              cmd.walk_src  = SRC_START;
              cmd.walk_mode = WM_SET;
              mode_nxt      = WM_SET;
              state_nxt     = S_RD;
            end else begin
              stat_nxt = STAT_NO_MEM;
            end
          end
          WM_SET: begin
            cmd.fc_sub_n  = 1'b1;
            cmd.take_addr = 1'b1;
          end
          WM_CHK: begin
            if (st.hit) begin
              stat_nxt = STAT_ALREADY_FREE;
            end else begin
              cmd.walk_init = 1'b1;
              cmd.walk_src  = SRC_FIRST;
              cmd.walk_mode = WM_CLR;
              mode_nxt      = WM_CLR;
              state_nxt     = S_RD;
            end
          end
          WM_CLR: cmd.fc_add_n = 1'b1;
          WM_REL: stat_nxt = st.hit ? STAT_ALREADY_FREE : STAT_OK;
          default: stat_nxt = STAT_OK;
        endcase
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.finish    = 1'b1;
          cmd.stat      = stat_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      mode_r      <= WM_SCAN;
      stat_r      <= STAT_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      stat_r      <= stat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: src/bpa_datapath.sv
// Datapath of the bitmap page allocator: map memory, walk counters, checks.
module bpa_datapath #(
  parameter int MAX_PAGES     = bpa_pkg::MAX_PAGES_DEF,
  parameter int PAGE_BITS     = bpa_pkg::PAGE_BITS_DEF,
  parameter int MAP_WORD_BITS = bpa_pkg::MAP_WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bpa_pkg::bpa_cmd_t             cmd,
  output bpa_pkg::bpa_stat_t            st,
  input  logic [bpa_pkg::CMD_W-1:0]     in_cmd,
  input  logic [bpa_pkg::ADDR_W-1:0]    in_address,
  input  logic [bpa_pkg::CNT_W-1:0]     in_count,
  input  logic                          cfg_we,
  input  logic [bpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpa_pkg::ADDR_W-1:0]    cfg_wdata,
  output logic [bpa_pkg::STAT_W-1:0]    out_status,
  output logic [bpa_pkg::ADDR_W-1:0]    out_address_out,
  output logic                          out_page_is_free,
  output logic [bpa_pkg::CNT_W-1:0]     out_free_pages_now,
  output logic [bpa_pkg::CNT_W-1:0]     out_total_pages_now
);
  import bpa_pkg::*;

  localparam int DEPTH  = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int AWI    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BW     = $clog2(MAP_WORD_BITS);
  localparam int RCP_SH = CNT_W + BW + 1;
  localparam int RCP_W  = CNT_W + 3;
  localparam int PW     = RCP_SH + CNT_W;
  localparam longint RCP_L = ((longint'(1) << RCP_SH) + longint'(MAP_WORD_BITS) - 1) /
                             longint'(MAP_WORD_BITS);
  localparam logic [RCP_W-1:0] RCP       = RCP_W'(RCP_L);
  localparam logic [BW-1:0]    LAST_BIT  = BW'(MAP_WORD_BITS - 1);
  localparam logic [AWI-1:0]   LAST_WORD = AWI'(DEPTH - 1);

  // Configuration
  logic              cfg_en_r;
  logic [ADDR_W-1:0] cfg_base_r;
  logic [CNT_W-1:0]  cfg_total_r;
  logic [CNT_W-1:0]  eff;

  // Item and checks
  logic [CMD_W-1:0]  item_cmd_r;
  logic [ADDR_W-1:0] a_r;
  logic [CNT_W-1:0]  n_r;
  logic [ADDR_W:0]   diff_r;
  logic [ADDR_W-1:0] sp;
  logic [CNT_W:0]    run_sum;
  logic              addr_ok;
  logic [CNT_W-1:0]  free_r;

  // Map memory and walk
  logic [MAP_WORD_BITS-1:0] mem [DEPTH];
  logic [MAP_WORD_BITS-1:0] rdata_r, wbuf_r, mem_wd;
  logic [AWI-1:0]    mem_wa, waddr_r, clr_addr_r;
  logic              mem_we, dirty_r;
  logic [BW-1:0]     bidx_r;
  logic [MODE_W-1:0] mode_r;
  logic [CNT_W-1:0]  rem_r, run_r, p_r, start_p_r;
  logic [AWI-1:0]    start_w_r;
  logic [BW-1:0]     start_b_r;
  logic              walk_end_r, hit_r;
  logic              bitv, step_hit, step_last;
  logic [CNT_W-1:0]  run_inc;

  // Page to word/bit conversion
  logic [CNT_W-1:0]  dq_r;
  logic [BW-1:0]     rr_r;
  logic [PW-1:0]     dprod;
  logic [CNT_W-1:0]  dquo, dback, drem;
  logic              div_done_r;

  logic [ADDR_W-1:0] res_addr_r;
  logic              res_free_r;

  always_comb begin
    if (int'(cfg_total_r) > MAX_PAGES) begin
      eff = CNT_W'(MAX_PAGES);
    end else begin
      eff = cfg_total_r;
    end
  end

  assign sp      = diff_r[ADDR_W-1:0] >> PAGE_BITS;
  assign addr_ok = !diff_r[ADDR_W] && (sp < ADDR_W'(eff));
  assign run_sum = {1'b0, sp[CNT_W-1:0]} + {1'b0, n_r};

  // Word index by reciprocal multiply, exact for every page number of CNT_W bits.
  assign dprod = PW'(sp[CNT_W-1:0]) * PW'(RCP);
  assign dquo  = dprod[RCP_SH +: CNT_W];
  assign dback = dq_r * CNT_W'(MAP_WORD_BITS);
  assign drem  = sp[CNT_W-1:0] - dback;

  assign bitv    = wbuf_r[bidx_r];
  assign run_inc = run_r + 1'b1;

  always_comb begin
    step_hit  = 1'b0;
    step_last = (rem_r == CNT_W'(1));
    case (mode_r)
      WM_SCAN: begin
        step_hit  = !bitv && (run_inc == n_r);
        step_last = step_hit || (p_r == eff - 1'b1);
      end
      WM_CHK, WM_REL: begin
        step_hit  = !bitv;
        step_last = !bitv || (rem_r == CNT_W'(1));
      end
      WM_QRY:  step_last = 1'b1;
      default: step_hit = 1'b0;
    endcase
  end

  always_comb begin
    st            = '0;
    st.clr_last   = (clr_addr_r == LAST_WORD);
    st.enable     = cfg_en_r;
    st.cmd        = item_cmd_r;
    st.misaligned = (a_r[PAGE_BITS-1:0] != '0);
    st.n_zero     = (n_r == '0);
    st.free_lt_n  = (free_r < n_r);
    st.total_zero = (eff == '0);
    st.addr_ok    = addr_ok;
    st.run_ok     = addr_ok && (run_sum <= {1'b0, eff});
    st.div_done   = div_done_r;
    st.word_end   = (bidx_r == LAST_BIT);
    st.step_last  = step_last;
    st.walk_end   = walk_end_r;
    st.hit        = hit_r;
  end

  // Map memory: one write port shared by the clearing pass and write-back.
  assign mem_we = cmd.clr_wr || (cmd.wb && dirty_r);
  assign mem_wa = cmd.clr_wr ? clr_addr_r : waddr_r;
  assign mem_wd = cmd.clr_wr ? '1 : wbuf_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[waddr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_en_r    <= 1'b0;
      cfg_base_r  <= '0;
      cfg_total_r <= CNT_W'(4096);
      free_r      <= '0;
      clr_addr_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLE: cfg_en_r    <= cfg_wdata[0];
          CFG_BASE:   cfg_base_r  <= cfg_wdata;
          CFG_TOTAL:  cfg_total_r <= cfg_wdata[CNT_W-1:0];
          default:    cfg_en_r    <= cfg_en_r;
        endcase
      end
      if (cmd.clr_wr) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cmd.fc_add_n) begin
        free_r <= free_r + n_r;
      end else if (cmd.fc_sub_n) begin
        free_r <= free_r - n_r;
      end else if (cmd.bit_step && mode_r == WM_REL && bitv) begin
        free_r <= free_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_cmd_r <= in_cmd;
      a_r        <= in_address;
      n_r        <= in_count;
      res_addr_r <= '0;
      res_free_r <= 1'b0;
    end
    if (cmd.calc) begin
      diff_r <= {1'b0, a_r} - {1'b0, cfg_base_r};
    end
    // Split the first page into word and bit: quotient first, remainder next cycle.
    if (cmd.div_start) begin
      dq_r       <= dquo;
      rr_r       <= '0;
      div_done_r <= 1'b0;
    end else if (cmd.div_step) begin
      rr_r       <= drem[BW-1:0];
      div_done_r <= 1'b1;
    end
    if (cmd.walk_init) begin
      mode_r     <= cmd.walk_mode;
      rem_r      <= n_r;
      run_r      <= '0;
      p_r        <= '0;
      walk_end_r <= 1'b0;
      hit_r      <= 1'b0;
      case (cmd.walk_src)
        SRC_START: begin
          waddr_r <= start_w_r;
          bidx_r  <= start_b_r;
        end
        SRC_FIRST: begin
          waddr_r <= AWI'(dq_r);
          bidx_r  <= rr_r;
        end
        default: begin
          waddr_r <= '0;
          bidx_r  <= '0;
        end
      endcase
    end
    if (cmd.ld) begin
      wbuf_r  <= rdata_r;
      dirty_r <= 1'b0;
    end
    if (cmd.bit_step) begin
      rem_r      <= rem_r - 1'b1;
      p_r        <= p_r + 1'b1;
      walk_end_r <= step_last;
      hit_r      <= step_hit;
      if (bidx_r != LAST_BIT) begin
        bidx_r <= bidx_r + 1'b1;
      end
      case (mode_r)
        WM_SCAN: begin
          if (bitv) begin
            run_r <= '0;
          end else begin
            if (run_r == '0) begin
              start_p_r <= p_r;
              start_w_r <= waddr_r;
              start_b_r <= bidx_r;
            end
            run_r <= run_inc;
          end
        end
        WM_SET: begin
          wbuf_r[bidx_r] <= 1'b1;
          dirty_r        <= 1'b1;
        end
        WM_CLR: begin
          wbuf_r[bidx_r] <= 1'b0;
          dirty_r        <= 1'b1;
        end
        WM_REL: begin
          if (bitv) begin
            wbuf_r[bidx_r] <= 1'b0;
            dirty_r        <= 1'b1;
          end
        end
        WM_QRY:  res_free_r <= !bitv;
        default: dirty_r <= dirty_r;
      endcase
    end
    if (cmd.wb) begin
      waddr_r <= waddr_r + 1'b1;
      bidx_r  <= '0;
    end
    if (cmd.take_addr) begin
      res_addr_r <= cfg_base_r + (ADDR_W'(start_p_r) << PAGE_BITS);
    end
    if (cmd.finish) begin
      out_status          <= cmd.stat;
      out_address_out     <= res_addr_r;
      out_page_is_free    <= res_free_r;
      out_free_pages_now  <= cfg_en_r ? free_r : '0;
      out_total_pages_now <= cfg_en_r ? eff : '0;
    end
  end

endmodule

// File: src/bitmap_page_allocator.sv
// Top level of the bitmap page allocator: controller plus datapath.
// Commands that touch no map bit go through the calculate and decide states to the result.
// Each map walk reads, loads and writes back each map word, steps through its pages and then
// decides; free, release and query first find the word and bit of their first page.
// Throughput: one command at a time; the next transfer can be taken once the result is presented.
// Reset: synchronous; then a clearing pass over all DEPTH (512) map words marks every page used.
module bitmap_page_allocator #(
  parameter int MAX_PAGES     = bpa_pkg::MAX_PAGES_DEF,
  parameter int PAGE_BITS     = bpa_pkg::PAGE_BITS_DEF,
  parameter int MAP_WORD_BITS = bpa_pkg::MAP_WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bpa_pkg::CMD_W-1:0]     in_cmd,
  input  logic [bpa_pkg::ADDR_W-1:0]    in_address,
  input  logic [bpa_pkg::CNT_W-1:0]     in_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bpa_pkg::STAT_W-1:0]    out_status,
  output logic [bpa_pkg::ADDR_W-1:0]    out_address_out,
  output logic                          out_page_is_free,
  output logic [bpa_pkg::CNT_W-1:0]     out_free_pages_now,
  output logic [bpa_pkg::CNT_W-1:0]     out_total_pages_now,
  input  logic                          cfg_we,
  input  logic [bpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpa_pkg::ADDR_W-1:0]    cfg_wdata
);
  import bpa_pkg::*;

  bpa_cmd_t  cmd;
  bpa_stat_t st;

  // Sequence each command: checks, word/bit conversion, map walks, transfer.
  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .st        (st),
    .cmd       (cmd)
  );

  // Hold the map, counts, configuration and the result register.
  bpa_datapath #(
    .MAX_PAGES     (MAX_PAGES),
    .PAGE_BITS     (PAGE_BITS),
    .MAP_WORD_BITS (MAP_WORD_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .st                  (st),
    .in_cmd              (in_cmd),
    .in_address          (in_address),
    .in_count            (in_count),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .out_status          (out_status),
    .out_address_out     (out_address_out),
    .out_page_is_free    (out_page_is_free),
    .out_free_pages_now  (out_free_pages_now),
    .out_total_pages_now (out_total_pages_now)
  );

endmodule

// File: tb/sv/tb_bitmap_page_allocator.sv
// Self-checking testbench for the bitmap page allocator: scoreboard against a behavioral model.
`timescale 1ns / 100ps

module tb_bitmap_page_allocator;
  import bpa_pkg::*;

  localparam int NPAGES = MAX_PAGES_DEF;
  localparam int PGB    = PAGE_BITS_DEF;
  localparam logic [CMD_W-1:0] CMD_COUNTS = 3'd4;  // read counts; 5..7 act the same

  // One expected result transfer.
  typedef struct {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] addr;
    logic              is_free;
    logic [CNT_W-1:0]  free_now;
    logic [CNT_W-1:0]  total_now;
  } alloc_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     in_cmd = '0;
  logic [ADDR_W-1:0]    in_address = '0;
  logic [CNT_W-1:0]     in_count = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STAT_W-1:0]    out_status;
  logic [ADDR_W-1:0]    out_address_out;
  logic                 out_page_is_free;
  logic [CNT_W-1:0]     out_free_pages_now;
  logic [CNT_W-1:0]     out_total_pages_now;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0]    cfg_wdata = '0;

  bitmap_page_allocator dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow allocator state: one bit per page, 1 means used.
  logic [NPAGES-1:0] used_map;
  int unsigned       shadow_free;
  logic              alloc_en;
  logic [ADDR_W-1:0] region_base;
  logic [CNT_W-1:0]  region_pages;

  alloc_result_t pending_results[$];
  int  mismatches = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  allocs_granted = 0;
  bit  quiet = 1'b0;  // no idling on either side when set

  function automatic int unsigned managed_pages();
    return (int'(region_pages) > NPAGES) ? NPAGES : int'(region_pages);
  endfunction

  function automatic bit page_aligned(logic [ADDR_W-1:0] a);
    return a[PGB-1:0] == '0;
  endfunction

  function automatic bit addr_in_region(logic [ADDR_W-1:0] a);
    logic [63:0] top;
    top = 64'(region_base) + (64'(managed_pages()) << PGB);
    return (64'(a) >= 64'(region_base)) && (64'(a) < top);
  endfunction

  // Range checks shared by free and release; first page goes to first_pg.
  function automatic logic [STAT_W-1:0] check_span(logic [ADDR_W-1:0] a,
                                                   int unsigned n,
                                                   output int unsigned first_pg);
    logic [63:0] sp;
    first_pg = 0;
    if (!page_aligned(a)) return STAT_NOT_ALIGNED;
    if (n == 0) return STAT_OK;
    if (!addr_in_region(a)) return STAT_BAD_ADDR;
    sp = (64'(a) - 64'(region_base)) >> PGB;
    if (sp + 64'(n) > 64'(managed_pages())) return STAT_BAD_ADDR;
    first_pg = sp[31:0];
    return STAT_OK;
  endfunction

  // Apply one command to the shadow state and return what the block must answer.
  function automatic alloc_result_t apply_command(logic [CMD_W-1:0] c,
                                                  logic [ADDR_W-1:0] a,
                                                  logic [CNT_W-1:0] cnt);
    alloc_result_t r;
    int unsigned n, tot, run, start, first_pg, p;
    logic [63:0] ofs;
    n = 32'(cnt);
    tot = managed_pages();
    r.status = STAT_OK;
    r.addr = '0;
    r.is_free = 1'b0;
    if (!alloc_en) begin
      r.status = STAT_NOT_INIT;
    end else if (c == CMD_ALLOC) begin
      r.status = STAT_NO_MEM;
      run = 0;
      start = 0;
      if (n != 0 && shadow_free >= n) begin
        for (p = 0; p < tot; p++) begin
          if (used_map[p]) begin
            run = 0;
          end else begin
            if (run == 0) start = p;
            run++;
            if (run == n) begin
              for (int q = start; q < start + n; q++) used_map[q] = 1'b1;
              shadow_free -= n;
              r.addr = region_base + (ADDR_W'(start) << PGB);
              r.status = STAT_OK;
              break;
            end
          end
        end
      end
    end else if (c == CMD_FREE) begin
      r.status = check_span(a, n, first_pg);
      if (r.status == STAT_OK && n != 0) begin
        for (p = first_pg; p < first_pg + n; p++)
          if (!used_map[p]) r.status = STAT_ALREADY_FREE;
        if (r.status == STAT_OK) begin
          for (p = first_pg; p < first_pg + n; p++) used_map[p] = 1'b0;
          shadow_free += n;
        end
      end
    end else if (c == CMD_REL) begin
      r.status = check_span(a, n, first_pg);
      if (r.status == STAT_OK && n != 0) begin
        for (p = first_pg; p < first_pg + n; p++) begin
          if (!used_map[p]) begin
            r.status = STAT_ALREADY_FREE;
            break;
          end
          used_map[p] = 1'b0;
          shadow_free++;
        end
      end
    end else if (c == CMD_QUERY) begin
      if (!page_aligned(a)) begin
        r.status = STAT_NOT_ALIGNED;
      end else if (!addr_in_region(a)) begin
        r.status = STAT_BAD_ADDR;
      end else begin
        ofs = (64'(a) - 64'(region_base)) >> PGB;
        r.is_free = !used_map[ofs[11:0]];
      end
    end
    r.free_now  = alloc_en ? CNT_W'(shadow_free) : '0;
    r.total_now = alloc_en ? CNT_W'(tot) : '0;
    return r;
  endfunction

  // Hold the item until the block takes it; leave valid high for the caller.
  task automatic send_command(logic [CMD_W-1:0] c, logic [ADDR_W-1:0] a,
                              logic [CNT_W-1:0] cnt);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= c;
    in_address <= a;
    in_count   <= cnt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_command(c, a, cnt));
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write one register with the block idle, then mirror it in the shadow state.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_ENABLE: alloc_en = val[0];
      CFG_BASE:   region_base = val;
      CFG_TOTAL:  region_pages = val[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_region(bit en, logic [ADDR_W-1:0] b, logic [CNT_W-1:0] pages);
    write_reg(CFG_BASE, b);
    write_reg(CFG_TOTAL, ADDR_W'(pages));
    write_reg(CFG_ENABLE, ADDR_W'(en));
  endtask

  function automatic logic [ADDR_W-1:0] page_addr(int unsigned p);
    return region_base + (ADDR_W'(p) << PGB);
  endfunction

  // Every command must answer not initialized before the allocator is enabled.
  task automatic test_disabled();
    send_command(CMD_ALLOC, '0, 13'd1);
    send_command(CMD_REL, '0, 13'd4);
    send_command(CMD_QUERY, 48'h1000, '0);
    send_command(CMD_COUNTS, '0, '0);
  endtask

  // Directed corners over a small region.
  task automatic test_corners();
    set_region(1'b1, 48'h0000_1000_0000, 13'd64);
    send_command(CMD_ALLOC, '0, 13'd1);                 // nothing free yet
    send_command(CMD_REL, page_addr(0), 13'd64);        // free the whole region
    send_command(CMD_ALLOC, '0, '0);                    // zero pages
    send_command(CMD_ALLOC, '0, 13'd4096);              // more than free
    send_command(CMD_ALLOC, '0, 13'd3);
    send_command(CMD_ALLOC, '0, 13'd5);
    send_command(CMD_FREE, page_addr(1), 13'd1);
    send_command(CMD_ALLOC, '0, 13'd2);                 // hole too short, goes past it
    send_command(CMD_FREE, page_addr(0) + 48'd1, 13'd1); // unaligned
    send_command(CMD_FREE, page_addr(0) - 48'h1000, 13'd1); // below base
    send_command(CMD_FREE, page_addr(64), 13'd1);       // at region end
    send_command(CMD_FREE, page_addr(60), 13'd8);       // run past end
    send_command(CMD_FREE, page_addr(200), '0);         // zero pages, no range check
    send_command(CMD_FREE, page_addr(0), 13'd3);        // holds a free page
    send_command(CMD_REL, page_addr(2), 13'd8);         // span all used, released whole
    send_command(CMD_QUERY, page_addr(1), '0);
    send_command(CMD_QUERY, page_addr(20), '0);
    send_command(CMD_QUERY, page_addr(3) + 48'h800, '0);
    send_command(CMD_QUERY, 48'hFFFF_FFFF_F000, '0);
    send_command(3'd5, '0, '0);
    send_command(3'd6, 48'hFFFF_FFFF_FFFF, 13'h1FFF);
    send_command(3'd7, '0, '0);
    send_command(CMD_ALLOC, '0, 13'h1FFF);
  endtask

  // Mostly well-formed traffic inside the region, some malformed noise.
  task automatic test_random_traffic(int unsigned nitems, int unsigned max_run);
    int unsigned tot, r, pg;
    logic [ADDR_W-1:0] a;
    logic [CNT_W-1:0]  n;
    logic [CMD_W-1:0]  c;
    for (int i = 0; i < nitems; i++) begin
      tot = managed_pages();
      pg  = (tot == 0) ? 0 : $urandom_range(0, tot - 1);
      a   = page_addr(pg);
      n   = CNT_W'($urandom_range(1, max_run));
      r   = $urandom_range(0, 99);
      if (r < 30) begin
        c = CMD_ALLOC;
      end else if (r < 55) begin
        c = CMD_REL;
        n = CNT_W'($urandom_range(1, 2 * max_run));
      end else if (r < 70) begin
        c = CMD_FREE;
      end else if (r < 85) begin
        c = CMD_QUERY;
      end else if (r < 90) begin
        c = CMD_W'($urandom_range(4, 7));
      end else begin
        c = CMD_W'($urandom_range(0, 7));
        a = ADDR_W'({$urandom, $urandom});
        if ($urandom_range(0, 1)) a[PGB-1:0] = '0;
        n = (r < 95) ? CNT_W'($urandom) : CNT_W'($urandom_range(0, 3));
      end
      send_command(c, a, n);
    end
  endtask

  // Stall the result side in random bursts unless the run is in its quiet part.
  int unsigned stall_left = 0;
  int unsigned open_left = 0;
  always @(posedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (open_left != 0) begin
      open_left <= open_left - 1;
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 1)) stall_left <= $urandom_range(1, 19);
      else open_left <= $urandom_range(1, 40);
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    alloc_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result, status %0d", out_status);
      end else begin
        e = pending_results.pop_front();
        if (e.status == STAT_OK && e.addr != '0) allocs_granted++;
        if (out_status !== e.status || out_address_out !== e.addr ||
            out_page_is_free !== e.is_free || out_free_pages_now !== e.free_now ||
            out_total_pages_now !== e.total_now) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("mismatch #%0d exp st=%0d a=%h f=%0d fp=%0d tp=%0d ",
                   results_seen, e.status, e.addr, e.is_free, e.free_now, e.total_now);
            $display("got st=%0d a=%h f=%0d fp=%0d tp=%0d",
                     out_status, out_address_out, out_page_is_free, out_free_pages_now,
                     out_total_pages_now);
          end
        end
      end
    end
  end

  initial begin
    used_map     = '1;
    shadow_free  = 0;
    alloc_en     = 1'b0;
    region_base  = '0;
    region_pages = 13'd4096;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // let the post-reset clearing pass finish before touching registers
    repeat (600) @(posedge clk);

    test_disabled();
    test_corners();
    set_region(1'b1, 48'h0000_0000_0000, 13'd4096);
    test_random_traffic(120, 16);
    drain_results();  // sender waits for every outstanding result
    test_random_traffic(40, 16);
    set_region(1'b1, 48'hFFFF_FFFF_F000, 13'd1);
    test_random_traffic(40, 2);
    set_region(1'b1, 48'h1234_5678_9000, 13'd0);
    test_random_traffic(30, 4);
    set_region(1'b1, 48'h0000_8000_0000, 13'h1FFF);
    test_random_traffic(120, 24);
    set_region(1'b0, 48'h0000_0000_1000, 13'd4096);
    test_random_traffic(20, 8);
    set_region(1'b1, 48'hABCD_EF01_2000, 13'd256);
    test_random_traffic(100, 8);
    quiet = 1'b1;
    test_random_traffic(60, 8);

    drain_results();
    repeat (50) @(posedge clk);
    $display("covered %0d commands, %0d results, %0d granted allocations", items_sent,
             results_seen, allocs_granted);
    $display("regions: disabled, single page, empty, oversized, top-of-space base");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_bitmap_page_allocator OK");
    end else begin
      $display("tb_bitmap_page_allocator NOT OK");
    end
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("tb_bitmap_page_allocator NOT OK");
    $finish;
  end

endmodule
